/* rtl/peer_view_rotating_fanout_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the rotating fan-out table
// Concurrent checks on the block clock. They reduce to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef PEER_VIEW_ROTATING_FANOUT_MACROS_SVH
`define PEER_VIEW_ROTATING_FANOUT_MACROS_SVH
`ifndef SYNTH
`define PVRF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PVRF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PVRF_ASSERT_IMP(lbl, ante, cons, msg)
`define PVRF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/pvrf_pkg.sv */
// ----------------------------------------------------------------------------
// pvrf_pkg
// Shared types and constants of the rotating fan-out table.
// ----------------------------------------------------------------------------
package pvrf_pkg;

    localparam int REQ_W       = 2;
    localparam int FANOUT_W    = 5;
    localparam int SENT_W      = 5;
    localparam int OUT_CNT_W   = 5;
    localparam int MAX_RESULTS = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);

    localparam logic [FANOUT_W-1:0]  FANOUT_RESET = FANOUT_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FANOUT   = CFG_IDX_W'(1);

    typedef enum logic [REQ_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEND   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef struct packed {
        t_op  op;
        logic excl;
    } t_cmd_ctl;

endpackage

/* rtl/pvrf_if.sv */
// ----------------------------------------------------------------------------
// pvrf channel interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface pvrf_req_if #(parameter int ID_W = 64);
    import pvrf_pkg::*;

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [ID_W-1:0]  peer_id;
    logic             exclude_valid;

    modport source (output valid, req_type, peer_id, exclude_valid, input ready);
    modport sink (input valid, req_type, peer_id, exclude_valid, output ready);
endinterface

interface pvrf_rsp_if #(parameter int ID_W = 64);
    import pvrf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 status;
    logic                 dest_valid;
    logic [ID_W-1:0]      dest_peer;
    logic                 last;
    logic [SENT_W-1:0]    sent_so_far;
    logic [OUT_CNT_W-1:0] peer_count;

    modport source (output valid, status, dest_valid, dest_peer, last, sent_so_far,
                    peer_count, input ready);
    modport sink (input valid, status, dest_valid, dest_peer, last, sent_so_far,
                  peer_count, output ready);
endinterface

interface pvrf_cfg_if;
    import pvrf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/pvrf_front.sv */
// ----------------------------------------------------------------------------
// pvrf_front
// Accepts request transactions, decodes them and queues them for the engine.
// ----------------------------------------------------------------------------
module pvrf_front #(
    parameter int ID_W = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pvrf_req_if.sink           i_req,
    output logic               o_cmd_valid,
    output pvrf_pkg::t_cmd_ctl o_cmd,
    output logic [ID_W-1:0]    o_cmd_id,
    input  logic               i_cmd_ready
);
    import pvrf_pkg::*;

    t_cmd_ctl           r_q_ctl [Q_DEPTH];
    logic [ID_W-1:0]    r_q_id  [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_fill;

    t_cmd_ctl in_ctl;
    logic     push;
    logic     pop;

    always_comb begin
        case (i_req.req_type)
            OP_ADD:    in_ctl.op = OP_ADD;
            OP_REMOVE: in_ctl.op = OP_REMOVE;
            OP_SEND:   in_ctl.op = OP_SEND;
            default:   in_ctl.op = OP_NOP;
        endcase
        // The exclusion flag only means something on a send.
        in_ctl.excl = i_req.exclude_valid && (in_ctl.op == OP_SEND);
    end

    assign i_req.ready = (r_fill != (Q_PTR_W + 1)'(Q_DEPTH));
    assign push        = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_fill != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q_ctl[r_rd_ptr];
    assign o_cmd_id    = r_q_id[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_ctl[r_wr_ptr] <= in_ctl;
            r_q_id[r_wr_ptr]  <= i_req.peer_id;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

/* rtl/pvrf_engine.sv */
// ----------------------------------------------------------------------------
// pvrf_engine
// Holds the peer table and carries out add, remove and send requests.
// ----------------------------------------------------------------------------
module pvrf_engine #(
    parameter int MAX_PEERS = 16,
    parameter int ID_W      = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  pvrf_pkg::t_cmd_ctl            i_cmd,
    input  logic [ID_W-1:0]               i_cmd_id,
    input  logic [ID_W-1:0]               i_self_id,
    input  logic [pvrf_pkg::FANOUT_W-1:0] i_fanout,
    pvrf_rsp_if.source                    o_rsp
);
    import pvrf_pkg::*;

    localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CNT_W = $clog2(MAX_PEERS + 1);
    localparam int MW    = (CNT_W > SENT_W) ? CNT_W : SENT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REM_RD,
        S_REM_WR,
        S_MOD,
        S_SEND,
        S_FIN
    } t_state;

    // Peer table, one write and one registered read per cycle.
    logic [ID_W-1:0] r_table [MAX_PEERS];
    logic [ID_W-1:0] r_rd_data;
    logic            mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ID_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    t_state            r_state,     n_state;
    t_op               r_op,        n_op;
    logic [ID_W-1:0]   r_id,        n_id;
    logic              r_excl,      n_excl;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic [IDX_W-1:0]  r_cursor,    n_cursor;
    logic [IDX_W-1:0]  r_idx,       n_idx;
    logic [CNT_W-1:0]  r_iss,       n_iss;
    logic              r_chk_vld,   n_chk_vld;
    logic [IDX_W-1:0]  r_chk_idx,   n_chk_idx;
    logic [CNT_W-1:0]  r_checked,   n_checked;
    logic              r_found,     n_found;
    logic [IDX_W-1:0]  r_found_idx, n_found_idx;
    logic [SENT_W-1:0] r_sent,      n_sent;
    logic              r_hold_vld,  n_hold_vld;
    logic [ID_W-1:0]   r_hold_id,   n_hold_id;

    logic                 r_out_vld,      n_out_vld;
    logic                 r_out_status,   n_out_status;
    logic                 r_out_dest_vld, n_out_dest_vld;
    logic [ID_W-1:0]      r_out_dest,     n_out_dest;
    logic                 r_out_last,     n_out_last;
    logic [SENT_W-1:0]    r_out_sent,     n_out_sent;
    logic [OUT_CNT_W-1:0] r_out_count,    n_out_count;

    logic              out_free;
    logic              push;
    logic              push_status;
    logic              push_dest_vld;
    logic [ID_W-1:0]   push_dest;
    logic              push_last;
    logic [SENT_W-1:0] push_sent;

    logic [CNT_W-1:0]  last_idx;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  chk_inc;
    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  chk_next;
    logic [MW-1:0]     cap_a;
    logic [MW-1:0]     want_full;
    logic [SENT_W-1:0] want;
    logic              hit;
    logic              stall;
    logic              finish;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_table[mem_raddr];
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign out_free    = !r_out_vld || o_rsp.ready;
    assign last_idx    = r_count - 1'b1;

    // Walk positions wrap at the table count rather than at the table size.
    assign idx_inc  = CNT_W'(r_idx) + 1'b1;
    assign chk_inc  = CNT_W'(r_chk_idx) + 1'b1;
    assign idx_next = (idx_inc == r_count) ? '0 : idx_inc[IDX_W-1:0];
    assign chk_next = (chk_inc == r_count) ? '0 : chk_inc[IDX_W-1:0];

    assign cap_a     = (MW'(i_fanout) < MW'(r_count)) ? MW'(i_fanout) : MW'(r_count);
    assign want_full = (cap_a < MW'(MAX_RESULTS)) ? cap_a : MW'(MAX_RESULTS);
    assign want      = want_full[SENT_W-1:0];

    assign hit    = !(r_excl && (r_rd_data == r_id));
    assign stall  = r_chk_vld && hit && r_hold_vld && !out_free;
    assign finish = r_chk_vld && !stall &&
                    (((r_checked + 1'b1) == r_count) || (hit && ((r_sent + 1'b1) == want)));

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_id        = r_id;
        n_excl      = r_excl;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_idx       = r_idx;
        n_iss       = r_iss;
        n_chk_vld   = r_chk_vld;
        n_chk_idx   = r_chk_idx;
        n_checked   = r_checked;
        n_found     = r_found;
        n_found_idx = r_found_idx;
        n_sent      = r_sent;
        n_hold_vld  = r_hold_vld;
        n_hold_id   = r_hold_id;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_id;
        mem_raddr = r_idx;

        push          = 1'b0;
        push_status   = 1'b0;
        push_dest_vld = 1'b0;
        push_dest     = '0;
        push_last     = 1'b1;
        push_sent     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_op       = i_cmd.op;
                    n_id       = i_cmd_id;
                    n_excl     = i_cmd.excl;
                    n_iss      = '0;
                    n_chk_vld  = 1'b0;
                    n_found    = 1'b0;
                    n_checked  = '0;
                    n_sent     = '0;
                    n_hold_vld = 1'b0;
                    n_idx      = r_cursor;
                    case (i_cmd.op)
                        OP_ADD:    n_state = S_SCAN;
                        OP_REMOVE: n_state = S_SCAN;
                        OP_SEND:   n_state = (r_count == '0) ? S_FIN : S_MOD;
                        default:   n_state = S_FIN;
                    endcase
                end
            end

            S_SCAN: begin
                mem_raddr = r_iss[IDX_W-1:0];
                if (r_iss != r_count) begin
                    n_iss     = r_iss + 1'b1;
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_iss[IDX_W-1:0];
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (r_chk_vld && (r_rd_data == r_id)) begin
                    n_found     = 1'b1;
                    n_found_idx = r_chk_idx;
                end
                if ((r_iss == r_count) && !r_chk_vld) begin
                    if (r_op == OP_REMOVE) begin
                        if (r_found) begin
                            n_state = S_REM_RD;
                        end else if (out_free) begin
                            push    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else if (out_free) begin
                        if ((r_id != i_self_id) && !r_found) begin
                            if (r_count == CNT_W'(MAX_PEERS)) begin
                                push_status = 1'b1;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[IDX_W-1:0];
                                n_count   = r_count + 1'b1;
                            end
                        end
                        push    = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end

            S_REM_RD: begin
                mem_raddr = last_idx[IDX_W-1:0];
                n_state   = S_REM_WR;
            end

            S_REM_WR: begin
                // Keep reading the last entry so the data holds through a stall.
                mem_raddr = last_idx[IDX_W-1:0];
                if (out_free) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_found_idx;
                    mem_wdata = r_rd_data;
                    n_count   = last_idx;
                    push      = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            S_MOD: begin
                // A remove can leave the cursor at or above the count.
                if (CNT_W'(r_idx) >= r_count) begin
                    n_idx = IDX_W'(CNT_W'(r_idx) - r_count);
                end else if (want == '0) begin
                    n_cursor = r_idx;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_SEND;
                end
            end

            S_SEND: begin
                mem_raddr = stall ? r_chk_idx : r_idx;
                if (r_chk_vld && !stall) begin
                    n_checked = r_checked + 1'b1;
                    if (hit) begin
                        // A destination is held back one step so that the final one
                        // can carry the last marker.
                        if (r_hold_vld) begin
                            push          = 1'b1;
                            push_dest_vld = 1'b1;
                            push_dest     = r_hold_id;
                            push_last     = 1'b0;
                            push_sent     = r_sent;
                        end
                        n_hold_vld = 1'b1;
                        n_hold_id  = r_rd_data;
                        n_sent     = r_sent + 1'b1;
                    end
                end
                if (finish) begin
                    n_cursor  = chk_next;
                    n_chk_vld = 1'b0;
                    n_state   = S_FIN;
                end else if (!stall) begin
                    if (r_iss != r_count) begin
                        n_chk_vld = 1'b1;
                        n_chk_idx = r_idx;
                        n_idx     = idx_next;
                        n_iss     = r_iss + 1'b1;
                    end else begin
                        n_chk_vld = 1'b0;
                    end
                end
            end

            S_FIN: begin
                if (out_free) begin
                    push          = 1'b1;
                    push_dest_vld = r_hold_vld;
                    push_dest     = r_hold_vld ? r_hold_id : '0;
                    push_sent     = r_hold_vld ? r_sent : '0;
                    n_state       = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_vld      = r_out_vld && !o_rsp.ready;
        n_out_status   = r_out_status;
        n_out_dest_vld = r_out_dest_vld;
        n_out_dest     = r_out_dest;
        n_out_last     = r_out_last;
        n_out_sent     = r_out_sent;
        n_out_count    = r_out_count;
        if (push) begin
            n_out_vld      = 1'b1;
            n_out_status   = push_status;
            n_out_dest_vld = push_dest_vld;
            n_out_dest     = push_dest;
            n_out_last     = push_last;
            n_out_sent     = push_sent;
            n_out_count    = OUT_CNT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        r_op           <= n_op;
        r_id           <= n_id;
        r_excl         <= n_excl;
        r_idx          <= n_idx;
        r_iss          <= n_iss;
        r_chk_idx      <= n_chk_idx;
        r_checked      <= n_checked;
        r_found        <= n_found;
        r_found_idx    <= n_found_idx;
        r_sent         <= n_sent;
        r_hold_vld     <= n_hold_vld;
        r_hold_id      <= n_hold_id;
        r_out_status   <= n_out_status;
        r_out_dest_vld <= n_out_dest_vld;
        r_out_dest     <= n_out_dest;
        r_out_last     <= n_out_last;
        r_out_sent     <= n_out_sent;
        r_out_count    <= n_out_count;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cursor  <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cursor  <= n_cursor;
            r_chk_vld <= n_chk_vld;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.dest_valid  = r_out_dest_vld;
    assign o_rsp.dest_peer   = r_out_dest;
    assign o_rsp.last        = r_out_last;
    assign o_rsp.sent_so_far = r_out_sent;
    assign o_rsp.peer_count  = r_out_count;

endmodule

/* rtl/peer_view_rotating_fanout.sv */
// ----------------------------------------------------------------------------
// peer_view_rotating_fanout
// Peer table with add, remove and rotating multicast destination selection.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake    Payload
// i_req    in   valid/ready  req_type, peer_id, exclude_valid
// o_rsp    out  valid/ready  status, dest_valid, dest_peer, last, sent_so_far, peer_count
// i_cfg    in   valid/ready  index, data (ready is always high)
//
// An add or a remove scans the table at one entry per cycle, and a remove that finds its entry
// then moves the last entry into the hole. A send scans from the cursor; when a remove left
// the cursor at or above the count, the count is first subtracted from it until it lies below.
// A send on an empty table, or with a zero fanout, scans nothing.
// The single read port of the peer table paces these scans. Reset is synchronous; it clears
// the count, the cursor and the two-entry request queue, which takes transactions while it
// has room, also while the output register is stalled.
`include "peer_view_rotating_fanout_macros.svh"

module peer_view_rotating_fanout #(
    parameter int MAX_PEERS    = 16,
    parameter int PEER_ID_BITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pvrf_req_if.sink   i_req,
    pvrf_cfg_if.sink   i_cfg,
    pvrf_rsp_if.source o_rsp
);
    import pvrf_pkg::*;

    logic [CFG_DATA_W-1:0] r_self_id;
    logic [FANOUT_W-1:0]   r_fanout;

    logic                    cmd_valid;
    logic                    cmd_ready;
    t_cmd_ctl                cmd_ctl;
    logic [PEER_ID_BITS-1:0] cmd_id;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id <= '0;
            r_fanout  <= FANOUT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SELF_ID: r_self_id <= i_cfg.data;
                CFG_FANOUT:  r_fanout  <= i_cfg.data[FANOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pvrf_front #(
        .ID_W (PEER_ID_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd_ctl),
        .o_cmd_id    (cmd_id),
        .i_cmd_ready (cmd_ready)
    );

    pvrf_engine #(
        .MAX_PEERS (MAX_PEERS),
        .ID_W      (PEER_ID_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd_ctl),
        .i_cmd_id    (cmd_id),
        .i_self_id   (r_self_id[PEER_ID_BITS-1:0]),
        .i_fanout    (r_fanout),
        .o_rsp       (o_rsp)
    );

    `PVRF_ASSERT_IMP(a_dest_counted, o_rsp.valid && o_rsp.dest_valid,
        o_rsp.sent_so_far != '0 && !o_rsp.status, "destination result without a send count")
    `PVRF_ASSERT_IMP(a_empty_result, o_rsp.valid && !o_rsp.dest_valid,
        o_rsp.last && o_rsp.sent_so_far == '0 && o_rsp.dest_peer == '0,
        "non-destination result is not a clean final result")
    `PVRF_ASSERT_IMP(a_full_on_add, o_rsp.valid && o_rsp.status,
        o_rsp.last && !o_rsp.dest_valid, "table full reported on a destination result")
    `PVRF_ASSERT_NXT(a_engine_busy, cmd_valid && cmd_ready, !cmd_ready,
        "engine took a second request in back-to-back cycles")

endmodule

/* dv/pvrf_fanout_checker.sv */
// ----------------------------------------------------------------------------
// pvrf_fanout_checker
// Watches the request, configuration and response channels of the rotating
// fan-out table. It keeps its own copy of the peer table, count, cursor and
// registers. Each accepted request is turned into the response transactions
// it should produce. Every accepted response is then compared field by field
// with the oldest one still awaited.
// ----------------------------------------------------------------------------
module pvrf_fanout_checker #(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_W        = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pvrf_req_if  i_req,
    pvrf_rsp_if  i_rsp,
    pvrf_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import pvrf_pkg::*;

    typedef struct {
        logic                 status;
        logic                 dest_valid;
        logic [ID_W-1:0]      dest_peer;
        logic                 last;
        logic [SENT_W-1:0]    sent_so_far;
        logic [OUT_CNT_W-1:0] peer_count;
    } t_reply;

    logic [ID_W-1:0]     roster [TABLE_DEPTH];
    int                  roster_len;
    int                  rot_pos;
    logic [ID_W-1:0]     own_id;
    logic [FANOUT_W-1:0] fan_limit;
    t_reply              awaited_replies [$];
    int                  fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int find_roster(logic [ID_W-1:0] id);
        for (int i = 0; i < roster_len; i++) begin
            if (roster[i] == id) return i;
        end
        return -1;
    endfunction

    function automatic t_reply make_reply(logic st, logic dv, logic [ID_W-1:0] dp,
                                          logic lst, int sent);
        t_reply r;
        r.status      = st;
        r.dest_valid  = dv;
        r.dest_peer   = dp;
        r.last        = lst;
        r.sent_so_far = SENT_W'(sent);
        r.peer_count  = OUT_CNT_W'(roster_len);
        return r;
    endfunction

    task automatic predict_fanout_replies(t_op op, logic [ID_W-1:0] id, logic excl);
        int   slot;
        int   want;
        int   sent;
        int   scanned;
        int   pos;
        logic st;
        st = 1'b0;
        case (op)
            OP_ADD: begin
                if (id != own_id && find_roster(id) < 0) begin
                    if (roster_len >= TABLE_DEPTH) begin
                        st = 1'b1;
                    end else begin
                        roster[roster_len] = id;
                        roster_len++;
                    end
                end
                awaited_replies.push_back(make_reply(st, 1'b0, '0, 1'b1, 0));
            end
            OP_REMOVE: begin
                slot = find_roster(id);
                if (slot >= 0) begin
                    roster[slot] = roster[roster_len-1];
                    roster_len--;
                end
                awaited_replies.push_back(make_reply(1'b0, 1'b0, '0, 1'b1, 0));
            end
            OP_SEND: begin
                if (roster_len == 0) begin
                    awaited_replies.push_back(make_reply(1'b0, 1'b0, '0, 1'b1, 0));
                end else begin
                    want = (int'(fan_limit) < roster_len) ? int'(fan_limit) : roster_len;
                    if (want > MAX_RESULTS) want = MAX_RESULTS;
                    sent    = 0;
                    scanned = 0;
                    while (scanned < roster_len && sent < want) begin
                        pos = (rot_pos + scanned) % roster_len;
                        if (!(excl && roster[pos] == id)) begin
                            awaited_replies.push_back(
                                make_reply(1'b0, 1'b1, roster[pos], 1'b0, sent + 1));
                            sent++;
                        end
                        scanned++;
                    end
                    // The cursor moves past excluded entries as well as chosen ones.
                    rot_pos = (rot_pos + scanned) % roster_len;
                    if (sent == 0) begin
                        awaited_replies.push_back(make_reply(1'b0, 1'b0, '0, 1'b1, 0));
                    end else begin
                        awaited_replies[awaited_replies.size()-1].last = 1'b1;
                    end
                end
            end
            default: begin
                awaited_replies.push_back(make_reply(1'b0, 1'b0, '0, 1'b1, 0));
            end
        endcase
    endtask

    task automatic check_reply();
        t_reply exp_r;
        if (awaited_replies.size() == 0) begin
            $error("response transaction with nothing awaited: dest_peer %h", i_rsp.dest_peer);
            fails++;
        end else begin
            exp_r = awaited_replies.pop_front();
            if (i_rsp.status !== exp_r.status) begin
                $error("status: expected %0d, actual %0d", exp_r.status, i_rsp.status);
                fails++;
            end
            if (i_rsp.dest_valid !== exp_r.dest_valid) begin
                $error("dest_valid: expected %0d, actual %0d", exp_r.dest_valid,
                       i_rsp.dest_valid);
                fails++;
            end
            if (i_rsp.dest_peer !== exp_r.dest_peer) begin
                $error("dest_peer: expected %h, actual %h", exp_r.dest_peer, i_rsp.dest_peer);
                fails++;
            end
            if (i_rsp.last !== exp_r.last) begin
                $error("last: expected %0d, actual %0d", exp_r.last, i_rsp.last);
                fails++;
            end
            if (i_rsp.sent_so_far !== exp_r.sent_so_far) begin
                $error("sent_so_far: expected %0d, actual %0d", exp_r.sent_so_far,
                       i_rsp.sent_so_far);
                fails++;
            end
            if (i_rsp.peer_count !== exp_r.peer_count) begin
                $error("peer_count: expected %0d, actual %0d", exp_r.peer_count,
                       i_rsp.peer_count);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) roster[i] = '0;
            roster_len = 0;
            rot_pos    = 0;
            own_id     = '0;
            fan_limit  = FANOUT_RESET;
            awaited_replies.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_SELF_ID) begin
                    own_id = i_cfg.data[ID_W-1:0];
                end else if (i_cfg.index == CFG_FANOUT) begin
                    fan_limit = i_cfg.data[FANOUT_W-1:0];
                end
            end
            // A response can never stem from a request accepted on the same edge.
            if (i_rsp.valid && i_rsp.ready) check_reply();
            if (i_req.valid && i_req.ready) begin
                predict_fanout_replies(t_op'(i_req.req_type), i_req.peer_id,
                                       i_req.exclude_valid);
            end
        end
        o_pending    <= awaited_replies.size();
        o_fail_count <= fails;
    end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the rotating fan-out table. A short directed sequence covers
// the empty table, own-id and duplicate adds, absent removes, full exclusion
// and the no-operation code. Six randomized phases with different register
// settings then fill and drain the table through a small id pool. Except in one quiet phase,
// both sides idle at random, and the response side holds off long enough to back up the
// request queue. A separate checker predicts and compares every transaction.
// ----------------------------------------------------------------------------
module tb_top;
    import pvrf_pkg::*;

    localparam int  ID_W        = 64;
    localparam int  POOL_SIZE   = 24;
    localparam int  IDLE_PCT    = 27;
    localparam int  HOLD_CYCLES = 400;
    localparam int  DRAIN_WAIT  = 60;
    localparam int  CYCLE_LIMIT = 600000;
    localparam logic [ID_W-1:0] ONES = '1;
    localparam logic [ID_W-1:0] MSB  = {1'b1, {(ID_W-1){1'b0}}};

    logic i_clk = 1'b0;
    logic i_rst_n;

    pvrf_req_if #(.ID_W(ID_W)) req_ch ();
    pvrf_rsp_if #(.ID_W(ID_W)) rsp_ch ();
    pvrf_cfg_if                cfg_ch ();

    int fail_count;
    int pending;
    int cycle_cnt     = 0;
    int n_requests    = 0;
    int n_sends       = 0;
    int n_results     = 0;
    int req_idle_pct  = IDLE_PCT;
    int rsp_stall_pct = IDLE_PCT;
    int hold_token    = 0;

    logic [ID_W-1:0] id_pool [POOL_SIZE];

    peer_view_rotating_fanout #(
        .MAX_PEERS   (16),
        .PEER_ID_BITS(ID_W)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .i_cfg  (cfg_ch),
        .o_rsp  (rsp_ch)
    );

    pvrf_fanout_checker #(
        .TABLE_DEPTH(16),
        .ID_W       (ID_W)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .i_cfg       (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d responses awaited", cycle_cnt, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Response side: random stalls, plus a long hold-off whenever the token moves.
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) n_results++;
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(99) < 85) return id_pool[$urandom_range(POOL_SIZE-1)];
        return {$urandom, $urandom};
    endfunction

    // Valid stays high after a transaction; the next call lowers it only while it idles, and a drain lowers it.
    task automatic issue(t_op op, logic [ID_W-1:0] id, logic excl);
        while ($urandom_range(99) < req_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= op;
        req_ch.peer_id       <= id;
        req_ch.exclude_valid <= excl;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        n_requests++;
        if (op == OP_SEND) n_sends++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [ID_W-1:0] own, logic [FANOUT_W-1:0] fan);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_SELF_ID;
        cfg_ch.data  <= CFG_DATA_W'(own);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.index <= CFG_FANOUT;
        cfg_ch.data  <= CFG_DATA_W'(fan);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(logic [ID_W-1:0] own, logic [FANOUT_W-1:0] fan, int add_pct,
                             int rem_pct, int items, bit quiet, int hold_at);
        int r;
        t_op op;
        wait_drained();
        write_regs(own, fan);
        if (quiet) begin
            req_idle_pct = 0;
            rsp_stall_pct <= 0;
        end
        for (int k = 0; k < items; k++) begin
            if (k == hold_at) hold_token <= hold_token + 1;
            r = $urandom_range(99);
            if (r < 2) op = OP_NOP;
            else if (r < 2 + add_pct) op = OP_ADD;
            else if (r < 2 + add_pct + rem_pct) op = OP_REMOVE;
            else op = OP_SEND;
            issue(op, pick_id(), 1'($urandom_range(1)));
        end
        if (quiet) begin
            req_idle_pct = IDLE_PCT;
            rsp_stall_pct <= IDLE_PCT;
        end
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= OP_NOP;
        req_ch.peer_id       <= '0;
        req_ch.exclude_valid <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_SELF_ID;
        cfg_ch.data          <= '0;

        id_pool[0] = '0;
        id_pool[1] = ONES;
        id_pool[2] = ID_W'(1);
        id_pool[3] = MSB;
        id_pool[4] = ~MSB;
        for (int i = 5; i < POOL_SIZE; i++) id_pool[i] = {$urandom, $urandom};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with the registers at their reset values.
        issue(OP_SEND, '0, 1'b0);
        issue(OP_SEND, ID_W'(5), 1'b1);
        issue(OP_REMOVE, ID_W'(64'h1234), 1'b0);
        issue(OP_ADD, '0, 1'b0);
        issue(OP_ADD, ONES, 1'b0);
        issue(OP_ADD, ONES, 1'b1);
        issue(OP_SEND, ONES, 1'b1);
        issue(OP_SEND, ONES, 1'b0);
        issue(OP_ADD, ID_W'(1), 1'b0);
        issue(OP_ADD, MSB, 1'b0);
        issue(OP_ADD, ~MSB, 1'b0);
        issue(OP_ADD, id_pool[5], 1'b1);
        issue(OP_SEND, '0, 1'b0);
        issue(OP_SEND, ID_W'(1), 1'b1);
        issue(OP_REMOVE, ONES, 1'b0);
        issue(OP_REMOVE, MSB, 1'b1);
        issue(OP_SEND, '0, 1'b0);
        issue(OP_NOP, {$urandom, $urandom}, 1'b1);
        issue(OP_SEND, ~MSB, 1'b1);

        // Randomized phases with different add and remove mixes fill and drain the table.
        run_phase(id_pool[3], FANOUT_W'(16), 60, 15, 80, 1'b0, 20);
        run_phase(ONES, FANOUT_W'(1), 30, 35, 70, 1'b1, -1);
        run_phase('0, FANOUT_W'($urandom_range(15, 2)), 45, 25, 70, 1'b0, -1);
        run_phase({$urandom, $urandom}, FANOUT_W'(16), 55, 10, 70, 1'b0, 30);
        run_phase(id_pool[0], FANOUT_W'($urandom_range(16, 1)), 20, 50, 70, 1'b0, -1);
        run_phase(id_pool[7], FANOUT_W'(3), 40, 25, 70, 1'b0, -1);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Run covered %0d requests, %0d of them sends, and %0d responses in %0d cycles.",
                 n_requests, n_sends, n_results, cycle_cnt);
        $display("Register settings spanned fanout 1 to 16 and own ids at both extremes.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
